// ===== src/kwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared widths, constants and types for the k-way timestamp merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int MAX_STREAMS = 8;
  localparam int SID_W       = 3;
  localparam int CNT_W       = 4;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0]  STREAM_COUNT_RESET = 4'd8;
  localparam logic [CNT_W-1:0]  STREAM_COUNT_MAX   = CNT_W'(MAX_STREAMS);
  localparam logic [DATA_W-1:0] COUNT_MAX          = '1;

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_END     = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] bytes;
    logic [DATA_W-1:0] obj;
    logic [DATA_W-1:0] ts;
  } head_t;

  typedef struct packed {
    logic              en;
    logic [SID_W-1:0]  addr;
    head_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic [DATA_W-1:0] number;
    logic [DATA_W-1:0] bytes;
    logic [DATA_W-1:0] obj;
    logic [DATA_W-1:0] ts;
  } res_t;

endpackage

// ===== src/kway_timestamp_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_timestamp_merge
// Merges up to eight timestamp-ordered request streams into one ordered
// stream, smallest head first, ties to the lowest stream number.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid / s_tready  s_tuser action,stream_id; s_tdata request
//   m_       out  m_tvalid / m_tready  m_tdata ts,object,size,item_number
//   cfg_     in   cfg_valid/cfg_ready  cfg_data stream_count
//
// Before an emission, the head memory is read one entry per cycle through
// its single read port, over the effective stream count, to find the
// minimum timestamp. The output register holds a result while the next
// item is accepted; a stalled output holds the block in its emit step.
// Reset is synchronous and clears all stream flags, the count and the
// stream count (back to eight).
// ----------------------------------------------------------------------------
module kway_timestamp_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [95:0]               s_tdata,   // timestamp, object_id, object_size
  input  logic [3:0]                s_tuser,   // action, stream_id
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [127:0]              m_tdata,   // out_timestamp, out_object_id,
                                               // out_size, item_number
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [kwm_pkg::CNT_W-1:0] cfg_data   // stream_count
);
  import kwm_pkg::*;

  logic [CNT_W-1:0] stream_count;
  head_t            in_head;
  logic             emit_valid;
  logic             emit_ready;
  res_t             emit_res;
  res_t             out_res;
  ram_wr_t          ram_wr;
  logic             ram_rd_en;
  logic [SID_W-1:0] ram_rd_addr;
  head_t            ram_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_count <= STREAM_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stream_count <= cfg_data;
    end
  end

  assign in_head.ts    = s_tdata[31:0];
  assign in_head.obj   = s_tdata[63:32];
  assign in_head.bytes = s_tdata[95:64];

  assign emit_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_res <= emit_res;
    end
  end

  assign m_tdata = {out_res.number, out_res.bytes, out_res.obj, out_res.ts};

  kwm_merge_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .stream_count (stream_count),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (s_tuser[0]),
    .in_sid       (s_tuser[3:1]),
    .in_head      (in_head),
    .emit_valid   (emit_valid),
    .emit_ready   (emit_ready),
    .emit_res     (emit_res),
    .ram_wr       (ram_wr),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  kwm_head_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// ===== src/kwm_head_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_head_ram
// Head storage, one entry per stream: timestamp, object id and size.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kwm_head_ram (
  input  logic                     clk,
  input  kwm_pkg::ram_wr_t         wr,
  input  logic                     rd_en,
  input  logic [kwm_pkg::SID_W-1:0] rd_addr,
  output kwm_pkg::head_t           rd_data
);
  import kwm_pkg::*;

  head_t mem [MAX_STREAMS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/kwm_merge_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_merge_ctrl
// Stream flags, input handling and the sequential minimum search over the
// head memory, one entry per cycle, followed by the emission of the winner.
// ----------------------------------------------------------------------------
module kwm_merge_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [kwm_pkg::CNT_W-1:0] stream_count,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [kwm_pkg::SID_W-1:0] in_sid,
  input  kwm_pkg::head_t            in_head,
  output logic                      emit_valid,
  input  logic                      emit_ready,
  output kwm_pkg::res_t             emit_res,
  output kwm_pkg::ram_wr_t          ram_wr,
  output logic                      ram_rd_en,
  output logic [kwm_pkg::SID_W-1:0] ram_rd_addr,
  input  kwm_pkg::head_t            ram_rd_data
);
  import kwm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]             state;
  logic [MAX_STREAMS-1:0] head_valid;
  logic [MAX_STREAMS-1:0] stream_done;
  logic [DATA_W-1:0]      emit_count;
  logic [DATA_W-1:0]      count_next;

  logic [CNT_W-1:0]       scan_addr;
  logic                   rd_pend;
  logic [SID_W-1:0]       rd_idx;
  logic                   found;
  logic [SID_W-1:0]       best_idx;
  head_t                  best;

  logic [CNT_W-1:0]       n;
  logic                   accept;
  logic                   take;
  logic                   all_ready;
  logic                   any_head;
  logic                   emit_fire;
  logic                   scan_issue;

  assign n         = (stream_count > STREAM_COUNT_MAX) ? STREAM_COUNT_MAX : stream_count;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign take      = ({1'b0, in_sid} < n) && !head_valid[in_sid] && !stream_done[in_sid];
  assign emit_fire = (state == ST_EMIT) && emit_ready;
  assign scan_issue = (state == ST_SCAN) && (scan_addr < n);

  always_comb begin
    all_ready = 1'b1;
    any_head  = 1'b0;
    for (int s = 0; s < MAX_STREAMS; s++) begin
      if (CNT_W'(s) < n) begin
        if (!head_valid[s] && !stream_done[s]) begin
          all_ready = 1'b0;
        end
        if (head_valid[s]) begin
          any_head = 1'b1;
        end
      end
    end
  end

  assign count_next = (emit_count == COUNT_MAX) ? emit_count : emit_count + DATA_W'(1);

  assign ram_wr.en    = accept && take && (in_action == ACT_REQUEST);
  assign ram_wr.addr  = in_sid;
  assign ram_wr.data  = in_head;
  assign ram_rd_en    = scan_issue;
  assign ram_rd_addr  = scan_addr[SID_W-1:0];

  assign emit_valid      = (state == ST_EMIT);
  assign emit_res.ts     = best.ts;
  assign emit_res.obj    = best.obj;
  assign emit_res.bytes  = best.bytes;
  assign emit_res.number = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head_valid  <= '0;
      stream_done <= '0;
      emit_count  <= '0;
      rd_pend     <= 1'b0;
      found       <= 1'b0;
      scan_addr   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (take && (in_action == ACT_REQUEST)) begin
              head_valid[in_sid] <= 1'b1;
            end
            if (take && (in_action == ACT_END)) begin
              stream_done[in_sid] <= 1'b1;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          scan_addr <= '0;
          rd_pend   <= 1'b0;
          found     <= 1'b0;
          state     <= (all_ready && any_head) ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end
          rd_pend <= scan_issue;
          if (rd_pend && head_valid[rd_idx] && (!found || ram_rd_data.ts < best.ts)) begin
            found <= 1'b1;
          end
          if (!scan_issue && !rd_pend) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ready) begin
            head_valid[best_idx] <= 1'b0;
            emit_count           <= count_next;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_idx <= scan_addr[SID_W-1:0];
    end
    if (state == ST_SCAN && rd_pend && head_valid[rd_idx] &&
        (!found || ram_rd_data.ts < best.ts)) begin
      best     <= ram_rd_data;
      best_idx <= rd_idx;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_valid_and_done: assert property (@(posedge clk) disable iff (rst)
    (head_valid & stream_done) == '0)
    else $error("stream holds a head and is marked ended");

  a_emit_held_head: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> head_valid[best_idx] && found)
    else $error("emitting a stream that holds no head");

  a_emit_clears_head: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> !head_valid[$past(best_idx)])
    else $error("emitted head still marked valid");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    emit_fire && (emit_count != COUNT_MAX) |=> emit_count == $past(emit_count) + DATA_W'(1))
    else $error("emit count did not advance");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the k-way timestamp merge.
//
// A directed table covers the field extremes, dropped items and stream-count
// corner values. A long random run follows: per-stream ordered request
// sequences with random content, mixed with noise items. Both stream sides
// idle at random. Every accepted item is run through a local merge predictor,
// and each output transfer is compared field by field with the oldest
// expected result.
// ----------------------------------------------------------------------------
module tb;
  import kwm_pkg::*;

  typedef struct packed {
    logic              action;
    logic [SID_W-1:0]  sid;
    logic [DATA_W-1:0] ts;
    logic [DATA_W-1:0] obj;
    logic [DATA_W-1:0] size;
  } req_t;

  typedef struct {
    bit                is_cfg;
    logic [CNT_W-1:0]  cfg;
    req_t              req;
    bit                typed;
    logic [DATA_W-1:0] num;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [95:0]        s_tdata = '0;    // timestamp, object_id, object_size
  logic [3:0]         s_tuser = '0;    // action, stream_id
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [127:0]       m_tdata;         // out_timestamp, out_object_id, out_size,
                                       // item_number
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data = '0;   // stream_count

  kway_timestamp_merge dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("FAIL kway_timestamp_merge");
    $finish;
  end

  // merge state mirror
  logic [CNT_W-1:0]  stream_cfg = STREAM_COUNT_RESET;
  bit                head_held    [MAX_STREAMS];
  logic [DATA_W-1:0] head_ts      [MAX_STREAMS];
  logic [DATA_W-1:0] head_obj     [MAX_STREAMS];
  logic [DATA_W-1:0] head_size    [MAX_STREAMS];
  bit                stream_ended [MAX_STREAMS];
  logic [DATA_W-1:0] emitted_total = '0;
  logic [DATA_W-1:0] last_ts      [MAX_STREAMS];

  res_t pending_results[$];
  row_t plan[$];
  int   fail_count = 0;

  bit   calm = 1'b0;
  bit   hold_go = 1'b0;
  logic sink_hold = 1'b0;
  int   sink_run = 0;

  res_t want_res, got_res;

  function automatic bit predict_merge(input req_t r, output bit taken, output res_t res);
    int n;
    int best;
    int s;
    bit found;
    n = (stream_cfg > STREAM_COUNT_MAX) ? MAX_STREAMS : int'(stream_cfg);
    res = '0;
    taken = (int'(r.sid) < n) && !head_held[r.sid] && !stream_ended[r.sid];
    if (taken) begin
      if (r.action == ACT_REQUEST) begin
        head_held[r.sid] = 1'b1;
        head_ts[r.sid]   = r.ts;
        head_obj[r.sid]  = r.obj;
        head_size[r.sid] = r.size;
      end else begin
        stream_ended[r.sid] = 1'b1;
      end
    end
    found = 1'b0;
    best = 0;
    for (s = 0; s < n; s++) begin
      if (!head_held[s] && !stream_ended[s]) return 1'b0;
      if (head_held[s] && (!found || head_ts[s] < head_ts[best])) begin
        best = s;
        found = 1'b1;
      end
    end
    if (!found) return 1'b0;
    head_held[best] = 1'b0;
    if (emitted_total != COUNT_MAX) emitted_total++;
    res.ts     = head_ts[best];
    res.obj    = head_obj[best];
    res.bytes  = head_size[best];
    res.number = emitted_total;
    return 1'b1;
  endfunction

  function automatic int live_streams();
    int cnt;
    cnt = 0;
    for (int s = 0; s < MAX_STREAMS; s++)
      if (!stream_ended[s]) cnt++;
    return cnt;
  endfunction

  function automatic logic [DATA_W-1:0] next_ts(int s);
    logic [DATA_W-1:0] step;
    logic [DATA_W-1:0] nxt;
    step = ($urandom_range(0, 9) == 0) ? $urandom : DATA_W'($urandom_range(0, 40));
    nxt = last_ts[s] + step;
    if (nxt < last_ts[s]) nxt = COUNT_MAX;
    last_ts[s] = nxt;
    return nxt;
  endfunction

  function automatic req_t next_request(int n);
    req_t r;
    int   cand[$];
    int   s;
    for (s = 0; s < n && s < MAX_STREAMS; s++)
      if (!head_held[s] && !stream_ended[s]) cand.push_back(s);
    r.obj  = $urandom;
    r.size = $urandom;
    if ($urandom_range(0, 99) < 80 && cand.size() != 0) begin
      s = cand[$urandom_range(0, cand.size() - 1)];
      r.sid = SID_W'(s);
      if (s != 0 && live_streams() > 3 && $urandom_range(0, 99) < 2) begin
        r.action = ACT_END;
        r.ts = $urandom;
      end else begin
        r.action = ACT_REQUEST;
        r.ts = next_ts(s);
      end
    end else begin
      r.sid = SID_W'($urandom_range(0, MAX_STREAMS - 1));
      r.ts = $urandom;
      r.action = $urandom_range(0, 1) ? ACT_END : ACT_REQUEST;
      if (r.action == ACT_END && int'(r.sid) < n && !head_held[r.sid] &&
          !stream_ended[r.sid])
        r.action = ACT_REQUEST;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %h got %h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void row_cfg(logic [CNT_W-1:0] v);
    row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg = v;
    plan.push_back(row);
  endfunction

  function automatic void row_req(logic action, int sid, logic [DATA_W-1:0] ts,
                                  logic [DATA_W-1:0] obj, logic [DATA_W-1:0] size);
    row_t row;
    row = '{default: '0};
    row.req = '{action, SID_W'(sid), ts, obj, size};
    plan.push_back(row);
  endfunction

  function automatic void row_exp(int sid, logic [DATA_W-1:0] ts, logic [DATA_W-1:0] obj,
                                  logic [DATA_W-1:0] size, logic [DATA_W-1:0] num);
    row_t row;
    row = '{default: '0};
    row.req = '{ACT_REQUEST, SID_W'(sid), ts, obj, size};
    row.typed = 1'b1;
    row.num = num;
    plan.push_back(row);
  endfunction

  task automatic idle_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!calm) begin
      if (r >= 93) gap = $urandom_range(10, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_item(input req_t r, input bit typed, input logic [DATA_W-1:0] num,
                           output bit taken);
    res_t res;
    bit   hit;
    idle_gap();
    s_tvalid <= 1'b1;
    s_tdata  <= {r.size, r.obj, r.ts};
    s_tuser  <= {r.sid, r.action};
    do @(posedge clk); while (!s_tready);
    hit = predict_merge(r, taken, res);
    if (typed) begin
      res.ts = r.ts;
      res.obj = r.obj;
      res.bytes = r.size;
      res.number = num;
      pending_results.push_back(res);
    end else if (hit) begin
      pending_results.push_back(res);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_stream_count(logic [CNT_W-1:0] v);
    drain();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    stream_cfg = v;
  endtask

  // output sink with random back-pressure
  always @(posedge clk) begin
    if (sink_hold) begin
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else if (sink_run == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        sink_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
      end else begin
        m_tready <= 1'b1;
        sink_run <= $urandom_range(1, 20);
      end
    end else begin
      sink_run <= sink_run - 1;
    end
  end

  // long output stall while the source keeps offering transfers
  initial begin
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = m_tdata;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("out_timestamp", want_res.ts, got_res.ts);
        check_field("out_object_id", want_res.obj, got_res.obj);
        check_field("out_size", want_res.bytes, got_res.bytes);
        check_field("item_number", want_res.number, got_res.number);
      end
    end
  end

  initial begin
    int   phase_counts[11] = '{8, 3, 1, 15, 5, 2, 0, 8, 6, 4, 8};
    int   eff;
    int   tries;
    int   n;
    int   cand[$];
    bit   taken;
    bit   paused;
    req_t r;

    for (int s = 0; s < MAX_STREAMS; s++) begin
      head_held[s] = 1'b0;
      stream_ended[s] = 1'b0;
      head_ts[s] = '0;
      head_obj[s] = '0;
      head_size[s] = '0;
      last_ts[s] = '0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single stream: every request leaves at once
    row_cfg(4'd1);
    row_exp(0, 32'h0, 32'h0, 32'h0, 32'd1);
    row_exp(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    row_req(ACT_REQUEST, 1, 32'h10, 32'h11, 32'h12);
    row_req(ACT_END, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    row_exp(0, 32'h5, 32'h1234_5678, 32'h400, 32'd3);
    // two streams: occupied drops, tie, end of stream
    row_cfg(4'd2);
    row_req(ACT_REQUEST, 1, 32'd100, 32'hA1, 32'hB1);
    row_req(ACT_REQUEST, 1, 32'd50, 32'hA2, 32'hB2);
    row_req(ACT_REQUEST, 0, 32'd100, 32'hA3, 32'hB3);
    row_req(ACT_END, 1, 32'h0, 32'h0, 32'h0);
    row_req(ACT_REQUEST, 0, 32'd200, 32'hA4, 32'hB4);
    row_req(ACT_END, 1, 32'h0, 32'h0, 32'h0);
    row_req(ACT_REQUEST, 1, 32'd300, 32'hA5, 32'hB5);
    // no stream takes part
    row_cfg(4'd0);
    row_req(ACT_REQUEST, 0, 32'd1, 32'd2, 32'd3);
    row_req(ACT_END, 2, 32'd1, 32'd2, 32'd3);
    // count above the maximum acts as eight
    row_cfg(4'd15);
    row_req(ACT_REQUEST, 0, 32'd900, 32'hC0, 32'hD0);
    row_req(ACT_REQUEST, 2, 32'd700, 32'hC2, 32'hD2);
    row_req(ACT_REQUEST, 3, 32'd300, 32'hC3, 32'hD3);
    row_req(ACT_REQUEST, 4, 32'd400, 32'hC4, 32'hD4);
    row_req(ACT_REQUEST, 5, 32'd300, 32'hC5, 32'hD5);
    row_req(ACT_REQUEST, 6, 32'd800, 32'hC6, 32'hD6);
    row_req(ACT_REQUEST, 7, 32'hFFFF_FFFF, 32'hC7, 32'hD7);
    row_req(ACT_END, 3, 32'h0, 32'h0, 32'h0);
    row_req(ACT_END, 4, 32'h0, 32'h0, 32'h0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_stream_count(plan[i].cfg);
      end else begin
        push_item(plan[i].req, plan[i].typed, plan[i].num, taken);
      end
    end

    for (int s = 0; s < MAX_STREAMS; s++)
      if (head_held[s]) last_ts[s] = head_ts[s];
    paused = 1'b0;

    for (int p = 0; p < 11; p++) begin
      set_stream_count(CNT_W'(phase_counts[p]));
      calm = (p == 3 || p == 7);
      n = (phase_counts[p] > MAX_STREAMS) ? MAX_STREAMS : phase_counts[p];
      if (n == 0) begin
        repeat (8) push_item(next_request(n), 1'b0, '0, taken);
      end else begin
        eff = 0;
        tries = 0;
        while (eff < 52 && tries < 240) begin
          push_item(next_request(n), 1'b0, '0, taken);
          tries++;
          if (taken) eff++;
          if (p == 0 && eff == 20) hold_go = 1'b1;
          if (p == 1 && eff == 30 && !paused) begin
            paused = 1'b1;
            drain();
          end
        end
      end
    end

    // close every stream, then offer items that must all be dropped
    tries = 0;
    while (live_streams() != 0 && tries < 200) begin
      cand.delete();
      for (int s = 0; s < MAX_STREAMS; s++)
        if (!head_held[s] && !stream_ended[s]) cand.push_back(s);
      if (cand.size() == 0) break;
      r.action = ACT_END;
      r.sid = SID_W'(cand[$urandom_range(0, cand.size() - 1)]);
      r.ts = $urandom;
      r.obj = $urandom;
      r.size = $urandom;
      push_item(r, 1'b0, '0, taken);
      tries++;
    end
    repeat (6) push_item(next_request(MAX_STREAMS), 1'b0, '0, taken);

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS kway_timestamp_merge");
    end else begin
      $display("FAIL kway_timestamp_merge");
    end
    $finish;
  end

endmodule
